[src/kct_pkg.sv]
// Shared types and constants for the keypad countdown timer.
package kct_pkg;

  localparam logic [3:0] KEY_STAR = 4'hE;
  localparam logic [3:0] KEY_HASH = 4'hF;
  localparam logic [3:0] KEY_DIGIT_LIMIT = 4'd10;

  localparam logic OP_KEY = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [6:0] FIELD_MAX = 7'd59;
  localparam logic [5:0] SECS_PER_MIN = 6'd60;

  localparam logic signed [8:0] READ_MAX = 9'sd200;
  localparam logic signed [8:0] READ_MIN = -9'sd200;

  localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

  localparam logic [7:0] TPS_RESET = 8'd20;
  localparam logic [7:0] DEB_RESET = 8'd4;

  localparam logic CFG_TPS = 1'b0;
  localparam logic CFG_DEB = 1'b1;

  localparam logic [2:0] POS_FULL = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ENTRY   = 3'd1,
    MODE_ARMED   = 3'd2,
    MODE_COUNT   = 3'd3,
    MODE_EXPIRED = 3'd4
  } mode_e;

  typedef struct packed {
    logic [1:0]        last_level;
    logic signed [8:0] reads;
  } deb_state_t;

  typedef struct packed {
    mode_e       mode;
    logic [2:0]  digits_entered;
    logic [11:0] remaining_seconds;
    logic        led_on;
  } result_t;

endpackage

[src/kct_debounce.sv]
// Key level debounce step with abort detection.
module kct_debounce (
  input  logic               level_i,
  input  logic [3:0]         key_i,
  input  logic [7:0]         deb_reads_i,
  input  kct_pkg::deb_state_t state_i,
  output kct_pkg::deb_state_t state_o,
  output logic               abort_o
);
  import kct_pkg::*;

  logic              same;
  logic signed [8:0] reads_n;

  assign same = (state_i.last_level == {1'b0, level_i});

  always_comb begin
    reads_n = state_i.reads;
    if (same) begin
      if (level_i) begin
        if (state_i.reads < READ_MAX) reads_n = state_i.reads + 9'sd1;
      end else begin
        if (state_i.reads > READ_MIN) reads_n = state_i.reads - 9'sd1;
      end
    end else begin
      reads_n = '0;
    end
  end

  assign state_o.last_level = {1'b0, level_i};
  assign state_o.reads = reads_n;
  assign abort_o = level_i && !reads_n[8] && (reads_n[7:0] == deb_reads_i) &&
                   (key_i == KEY_STAR);

endmodule

[src/kct_core.sv]
// Timer state registers and per-item state update.
module kct_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               op_i,
  input  logic [3:0]         key_code_i,
  input  logic               key_down_i,
  input  logic [7:0]         tps_i,
  input  logic [7:0]         deb_reads_i,
  output kct_pkg::result_t   result_o
);
  import kct_pkg::*;

  mode_e       mode_q, mode_d;
  logic [2:0]  pos_q, pos_d;
  logic [11:0] secs_q, secs_d;
  logic [7:0]  tick_q, tick_d;
  logic        led_q, led_d;
  deb_state_t  deb_q, deb_d, deb_n;
  logic        abort;
  logic [3:0]  digits_q [4];
  logic        digit_we;

  logic [6:0]  mins_raw, secs_raw;
  logic [5:0]  mins_c, secs_c;
  logic [11:0] total;
  logic [7:0]  tick_inc;

  kct_debounce u_debounce (
    .level_i    (key_down_i),
    .key_i      (key_code_i),
    .deb_reads_i(deb_reads_i),
    .state_i    (deb_q),
    .state_o    (deb_n),
    .abort_o    (abort)
  );

  assign mins_raw = 7'(digits_q[0]) * 7'd10 + 7'(digits_q[1]);
  assign secs_raw = 7'(digits_q[2]) * 7'd10 + 7'(key_code_i);
  assign mins_c   = (mins_raw > FIELD_MAX) ? FIELD_MAX[5:0] : mins_raw[5:0];
  assign secs_c   = (secs_raw > FIELD_MAX) ? FIELD_MAX[5:0] : secs_raw[5:0];
  assign total    = 12'(mins_c) * 12'(SECS_PER_MIN) + 12'(secs_c);
  assign tick_inc = tick_q + 8'd1;

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    secs_d   = secs_q;
    tick_d   = tick_q;
    led_d    = led_q;
    deb_d    = deb_q;
    digit_we = 1'b0;
    if (step_i) begin
      if (op_i == OP_KEY) begin
        unique case (mode_q)
          MODE_IDLE: begin
            if (key_code_i == KEY_STAR) begin
              mode_d = MODE_ENTRY;
              pos_d  = '0;
              secs_d = '0;
            end
          end
          MODE_ENTRY: begin
            if (key_code_i == KEY_STAR) begin
              pos_d  = '0;
              secs_d = '0;
            end else if (key_code_i < KEY_DIGIT_LIMIT) begin
              digit_we = 1'b1;
              pos_d    = pos_q + 3'd1;
              if (pos_q[1:0] == 2'd3) begin
                pos_d  = POS_FULL;
                secs_d = total;
                mode_d = MODE_ARMED;
              end
            end
          end
          MODE_ARMED: begin
            if (key_code_i == KEY_HASH) begin
              mode_d = MODE_COUNT;
              tick_d = '0;
            end else if (key_code_i == KEY_STAR) begin
              mode_d = MODE_ENTRY;
              pos_d  = '0;
              secs_d = '0;
            end
          end
          MODE_EXPIRED: begin
            if (key_code_i == KEY_HASH) begin
              led_d = 1'b0;
            end else if (key_code_i == KEY_STAR) begin
              led_d  = 1'b0;
              mode_d = MODE_ENTRY;
              pos_d  = '0;
              secs_d = '0;
            end
          end
          default: begin
          end
        endcase
      end else if (mode_q == MODE_COUNT) begin
        deb_d = deb_n;
        if (abort) begin
          led_d  = 1'b1;
          mode_d = MODE_EXPIRED;
        end else if (tick_inc == tps_i) begin
          tick_d = '0;
          if (secs_q == '0) begin
            led_d  = 1'b1;
            mode_d = MODE_EXPIRED;
          end else begin
            secs_d = secs_q - 12'd1;
          end
        end else begin
          tick_d = tick_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= MODE_IDLE;
      pos_q            <= '0;
      secs_q           <= '0;
      tick_q           <= '0;
      led_q            <= 1'b0;
      deb_q.last_level <= LEVEL_UNKNOWN;
      deb_q.reads      <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      secs_q <= secs_d;
      tick_q <= tick_d;
      led_q  <= led_d;
      deb_q  <= deb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (digit_we) begin
      digits_q[pos_q[1:0]] <= key_code_i;
    end
  end

  assign result_o.mode              = mode_d;
  assign result_o.digits_entered    = pos_d;
  assign result_o.remaining_seconds = secs_d;
  assign result_o.led_on            = led_d;

endmodule

[src/keypad_countdown_timer.sv]
// Keypad countdown timer top level: input register, core and result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries op_i, key_code_i and
//   key_down_i: a key press event (op 0) or a sample tick (op 1).
//   Output channel (out_valid_o / out_stall_i) returns one result per item:
//   mode, digits entered, remaining seconds and LED level after that item.
//   A transfer happens at a rising edge with valid high and stall low.
//   The item is held in the input register, passes through the core when the
//   result register is empty or being taken, and then waits in the result
//   register until it is taken.
//   Throughput: one item per cycle unless the receiver stalls; the state
//   update is a single pass through the core logic between the two registers.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_stall_o rises until the result is taken.
//   Reset puts the timer idle, LED off, tick and debounce state cleared,
//   ticks_per_second at 20 and debounce_reads at 4.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 ticks_per_second,
//   1 debounce_reads); the user must write only while the block is idle (not enforced).
module keypad_countdown_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [3:0]  key_code_i,
  input  logic        key_down_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  mode_o,
  output logic [2:0]  digits_entered_o,
  output logic [11:0] remaining_seconds_o,
  output logic        led_on_o
);
  import kct_pkg::*;

  logic [7:0] tps_val_q, deb_val_q;

  logic       in_valid_q;
  logic       op_q;
  logic [3:0] key_q;
  logic       level_q;
  logic       in_xfer;
  logic       adv;

  logic       out_valid_q;
  result_t    res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_val_q <= TPS_RESET;
      deb_val_q <= DEB_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TPS) tps_val_q <= cfg_data_i;
      if (cfg_idx_i == CFG_DEB) deb_val_q <= cfg_data_i;
    end
  end

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= op_i;
      key_q   <= key_code_i;
      level_q <= key_down_i;
    end
  end

  kct_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv),
    .op_i       (op_q),
    .key_code_i (key_q),
    .key_down_i (level_q),
    .tps_i      (tps_val_q),
    .deb_reads_i(deb_val_q),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mode_o              = res_q.mode;
  assign digits_entered_o    = res_q.digits_entered;
  assign remaining_seconds_o = res_q.remaining_seconds;
  assign led_on_o            = res_q.led_on;

`ifndef NO_ASSERTIONS
  a_led_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && led_on_o) |-> (mode_o == MODE_EXPIRED))
    else $error("LED lit outside expired mode");

  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o == MODE_IDLE || mode_o == MODE_ENTRY))
      |-> (remaining_seconds_o == 12'd0))
    else $error("nonzero time during idle or entry");

  a_count_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o == MODE_ARMED || mode_o == MODE_COUNT))
      |-> (digits_entered_o == POS_FULL))
    else $error("armed or counting without four digits");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (remaining_seconds_o <= 12'd3599))
    else $error("remaining time out of range");
`endif

endmodule
